@@ rtl/cmpc_pkg.sv @@
// Package with shared types, constants and float ordering functions for the max pool block.
`default_nettype none
package cmpc_pkg;

    localparam int DEF_MAX_CHANNELS = 256;
    localparam int SAMPLE_W = 32;
    localparam int CHIDX_W = 8;
    localparam int TAPS_W = 16;
    localparam int CCNT_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [TAPS_W-1:0]   RST_WINDOW_TAPS = 16'd9;
    localparam logic [CCNT_W-1:0]   RST_CHANNEL_COUNT = 9'd1;
    localparam logic [SAMPLE_W-1:0] RST_CLAMP_MAX = 32'h7F80_0000;
    localparam logic [SAMPLE_W-1:0] RST_CLAMP_MIN = 32'hFF80_0000;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_WINDOW_TAPS = 2'd0;
    localparam t_cfg_idx REG_CHANNEL_COUNT = 2'd1;
    localparam t_cfg_idx REG_CLAMP_MAX = 2'd2;
    localparam t_cfg_idx REG_CLAMP_MIN = 2'd3;

    typedef struct packed {
        logic first_tap;
        logic last_tap;
        logic last_ch;
    } t_ctrl;

    function automatic logic [SAMPLE_W-1:0] order_key(input logic [SAMPLE_W-1:0] v);
        return v[SAMPLE_W-1] ? ~v : {~v[SAMPLE_W-1], v[SAMPLE_W-2:0]};
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_max(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        return (order_key(b) > order_key(a)) ? b : a;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_min(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        return (order_key(b) < order_key(a)) ? b : a;
    endfunction

endpackage
`default_nettype wire

@@ rtl/cmpc_in_if.sv @@
// Input item channel carrying one sample.
`default_nettype none
interface cmpc_in_if;
    logic                          valid;
    logic                          ready;
    logic [cmpc_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ rtl/cmpc_out_if.sv @@
// Result item channel carrying the clamped channel maximum.
`default_nettype none
interface cmpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [cmpc_pkg::SAMPLE_W-1:0] pooled;
    logic [cmpc_pkg::CHIDX_W-1:0]  channel_index;
    logic                          pixel_last;

    modport source (output valid, output pooled, output channel_index, output pixel_last,
                    input ready);
    modport sink (input valid, input pooled, input channel_index, input pixel_last,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/cmpc_seq.sv @@
// Configuration registers and channel and tap position counters.
`default_nettype none
module cmpc_seq #(
    parameter int MAX_CHANNELS = cmpc_pkg::DEF_MAX_CHANNELS,
    parameter int AW = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire cmpc_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [cmpc_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  wire logic                          i_accept,
    output logic [AW-1:0]                      o_addr,
    output cmpc_pkg::t_ctrl                    o_ctrl,
    output logic [cmpc_pkg::SAMPLE_W-1:0]      o_clamp_max,
    output logic [cmpc_pkg::SAMPLE_W-1:0]      o_clamp_min
);
    import cmpc_pkg::*;

    localparam int MW = $clog2(MAX_CHANNELS + 1);
    localparam int EW = (MW > CCNT_W) ? MW : CCNT_W;

    logic [TAPS_W-1:0]   r_window_taps;
    logic [CCNT_W-1:0]   r_channel_count;
    logic [SAMPLE_W-1:0] r_clamp_max;
    logic [SAMPLE_W-1:0] r_clamp_min;
    logic [AW-1:0]       r_cpos;
    logic [TAPS_W-1:0]   r_tap;
    logic [AW-1:0]       n_cpos;
    logic [TAPS_W-1:0]   n_tap;
    logic [EW-1:0]       eff_ch;
    logic [TAPS_W-1:0]   eff_taps;
    logic                last_ch;
    logic                last_tap;

    always_comb begin
        if (r_channel_count == '0) begin
            eff_ch = EW'(1);
        end else if (EW'(r_channel_count) > EW'(MAX_CHANNELS)) begin
            eff_ch = EW'(MAX_CHANNELS);
        end else begin
            eff_ch = EW'(r_channel_count);
        end
        eff_taps = (r_window_taps == '0) ? TAPS_W'(1) : r_window_taps;
        last_ch  = (EW'(r_cpos) + EW'(1)) >= eff_ch;
        last_tap = ({1'b0, r_tap} + (TAPS_W + 1)'(1)) >= {1'b0, eff_taps};
        if (last_ch) begin
            n_cpos = '0;
            n_tap  = last_tap ? '0 : r_tap + TAPS_W'(1);
        end else begin
            n_cpos = r_cpos + AW'(1);
            n_tap  = r_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_taps   <= RST_WINDOW_TAPS;
            r_channel_count <= RST_CHANNEL_COUNT;
            r_clamp_max     <= RST_CLAMP_MAX;
            r_clamp_min     <= RST_CLAMP_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_TAPS: begin
                    r_window_taps <= i_cfg_data[TAPS_W-1:0];
                end
                REG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_data[CCNT_W-1:0];
                end
                REG_CLAMP_MAX: begin
                    r_clamp_max <= i_cfg_data;
                end
                REG_CLAMP_MIN: begin
                    r_clamp_min <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpos <= '0;
            r_tap  <= '0;
        end else if (i_accept) begin
            r_cpos <= n_cpos;
            r_tap  <= n_tap;
        end
    end

    assign o_addr             = r_cpos;
    assign o_ctrl.first_tap   = (r_tap == '0);
    assign o_ctrl.last_tap    = last_tap;
    assign o_ctrl.last_ch     = last_ch;
    assign o_clamp_max        = r_clamp_max;
    assign o_clamp_min        = r_clamp_min;

endmodule
`default_nettype wire

@@ rtl/cmpc_acc.sv @@
// Channel maximum store, compare stage and clamped result register.
`default_nettype none
module cmpc_acc #(
    parameter int MAX_CHANNELS = cmpc_pkg::DEF_MAX_CHANNELS,
    parameter int AW = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [cmpc_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [AW-1:0]                 i_addr,
    input  wire cmpc_pkg::t_ctrl               i_ctrl,
    input  wire logic [cmpc_pkg::SAMPLE_W-1:0] i_clamp_max,
    input  wire logic [cmpc_pkg::SAMPLE_W-1:0] i_clamp_min,
    input  wire logic                          i_out_ready,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    output logic [cmpc_pkg::SAMPLE_W-1:0]      o_pooled,
    output logic [cmpc_pkg::CHIDX_W-1:0]       o_channel_index,
    output logic                               o_pixel_last
);
    import cmpc_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_rdata;
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [AW-1:0]       r_s1_addr;
    t_ctrl               r_s1_ctrl;
    logic                r_lw_valid;
    logic [AW-1:0]       r_lw_addr;
    logic [SAMPLE_W-1:0] r_lw_data;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_pooled;
    logic [CHIDX_W-1:0]  r_chidx;
    logic                r_pixel_last;
    logic [SAMPLE_W-1:0] prev;
    logic [SAMPLE_W-1:0] acc;
    logic                out_free;
    logic                s1_adv;

    always_comb begin
        prev     = (r_lw_valid && (r_lw_addr == r_s1_addr)) ? r_lw_data : r_rdata;
        acc      = r_s1_ctrl.first_tap ? r_s1_sample : pick_max(prev, r_s1_sample);
        out_free = !r_out_valid || i_out_ready;
        s1_adv   = r_s1_valid && (!r_s1_ctrl.last_tap || out_free);
    end

    assign o_in_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_addr] <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_sample <= i_sample;
            r_s1_addr   <= i_addr;
            r_s1_ctrl   <= i_ctrl;
        end
        if (s1_adv) begin
            r_lw_addr <= r_s1_addr;
            r_lw_data <= acc;
        end
        if (s1_adv && r_s1_ctrl.last_tap) begin
            r_pooled     <= pick_max(pick_min(acc, i_clamp_max), i_clamp_min);
            r_chidx      <= CHIDX_W'(r_s1_addr);
            r_pixel_last <= r_s1_ctrl.last_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_lw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_lw_valid <= 1'b1;
            end
            if (s1_adv && r_s1_ctrl.last_tap) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pooled        = r_pooled;
    assign o_channel_index = r_chidx;
    assign o_pixel_last    = r_pixel_last;

endmodule
`default_nettype wire

@@ rtl/channelwise_max_pool_clamp.sv @@
// Top level of the channel-wise max pooling block with output clamp.
//
// Samples enter on i_sample_ch tap-major: tap 0 of every channel of a pixel,
// then tap 1 of every channel, and so on. Each item is compared against the
// stored running maximum of its channel, and on the last window tap the
// clamped maximum leaves on o_result_ch with its channel index and a flag on
// the last channel of the pixel.
// One item is accepted per cycle while input ready is high. A sample passes
// the registered read of the channel store, then the compare, clamp and
// the result register. The store has one write and one read port, and the
// most recent write is forwarded. Registers must be written through
// i_cfg_we, i_cfg_idx and i_cfg_data only while the block is idle; the
// block itself does not enforce this. Reset restores the register defaults
// and clears the channel and tap positions; the channel store is not
// cleared, since tap 0 ignores the stored value and overwrites it.
// When the receiver stalls, the result register holds, items with no result
// still move on, and input ready drops once a result waits behind the held one.
`default_nettype none
module channelwise_max_pool_clamp #(
    parameter int MAX_CHANNELS = cmpc_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    cmpc_in_if.sink                             i_sample_ch,
    cmpc_out_if.source                          o_result_ch,
    input  wire logic                           i_cfg_we,
    input  wire cmpc_pkg::t_cfg_idx             i_cfg_idx,
    input  wire logic [cmpc_pkg::SAMPLE_W-1:0]  i_cfg_data
);
    import cmpc_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic                accept;
    logic                in_ready;
    logic [AW-1:0]       addr;
    t_ctrl               ctrl;
    logic [SAMPLE_W-1:0] clamp_max;
    logic [SAMPLE_W-1:0] clamp_min;

    assign accept            = i_sample_ch.valid && in_ready;
    assign i_sample_ch.ready = in_ready;

    cmpc_seq #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .AW(AW)
    ) u_seq (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_accept(accept),
        .o_addr(addr),
        .o_ctrl(ctrl),
        .o_clamp_max(clamp_max),
        .o_clamp_min(clamp_min)
    );

    cmpc_acc #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .AW(AW)
    ) u_acc (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(accept),
        .i_sample(i_sample_ch.sample),
        .i_addr(addr),
        .i_ctrl(ctrl),
        .i_clamp_max(clamp_max),
        .i_clamp_min(clamp_min),
        .i_out_ready(o_result_ch.ready),
        .o_in_ready(in_ready),
        .o_out_valid(o_result_ch.valid),
        .o_pooled(o_result_ch.pooled),
        .o_channel_index(o_result_ch.channel_index),
        .o_pixel_last(o_result_ch.pixel_last)
    );

endmodule
`default_nettype wire

@@ rtl/cmpc_checker.sv @@
// Port-level checker for the max pool block and its bind statement.
`default_nettype none
module cmpc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [cmpc_pkg::SAMPLE_W-1:0] i_pooled,
    input wire logic [cmpc_pkg::CHIDX_W-1:0]  i_chidx
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result item dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_pooled) && $stable(i_chidx))
        else $error("Stalled result item changed.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result item present after reset.");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("Input stalled without a stalled result item.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("Input item withdrawn before it was accepted.");

endmodule

bind channelwise_max_pool_clamp cmpc_checker u_cmpc_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_sample_ch.valid),
    .i_in_ready(i_sample_ch.ready),
    .i_out_valid(o_result_ch.valid),
    .i_out_ready(o_result_ch.ready),
    .i_pooled(o_result_ch.pooled),
    .i_chidx(o_result_ch.channel_index)
);
`default_nettype wire
